// File: design/rc5d_pkg.sv
// Shared types, constants and table functions for the RC5 IR edge decoder.
// Depends on nothing; every other design file imports it.

package rc5d_pkg;

  // Frame and field geometry
  localparam int FRAME_BITS     = 13;
  localparam int LEFT_W         = 4;
  localparam int CFG_W          = 16;
  localparam int TICK_WIDTH_DEF = 16;
  localparam int Q_DEPTH        = 2;

  // Default pulse limits: nominal half bit plus or minus tolerance
  localparam logic [CFG_W-1:0] HALF_BIT_TICKS  = CFG_W'(900);
  localparam logic [CFG_W-1:0] TOLERANCE_TICKS = CFG_W'(270);
  localparam logic [CFG_W-1:0] ONE_T_MIN_RST   = HALF_BIT_TICKS - TOLERANCE_TICKS;
  localparam logic [CFG_W-1:0] ONE_T_MAX_RST   = HALF_BIT_TICKS + TOLERANCE_TICKS;
  localparam logic [CFG_W-1:0] TWO_T_MIN_RST   = CFG_W'(2 * 900 - 270);
  localparam logic [CFG_W-1:0] TWO_T_MAX_RST   = CFG_W'(2 * 900 + 270);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_T_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_T_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_T_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_T_MAX = 2'd3;

  // Field masks for the result
  localparam logic [5:0] CMD_LOW_MASK = 6'h3F;
  localparam logic [4:0] ADDR_MASK    = 5'h1F;

  typedef enum logic [1:0] {
    CLS_ONE_T = 2'd0,
    CLS_TWO_T = 2'd1,
    CLS_BAD   = 2'd2
  } pulse_cls_t;

  typedef enum logic [1:0] {
    ACT_ZERO = 2'd0,
    ACT_ONE  = 2'd1,
    ACT_NONE = 2'd2,
    ACT_BAD  = 2'd3
  } edge_act_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] pulse_ticks;
    logic        edge_rising;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  address;
    logic [6:0]  command;
    logic        toggle_bit;
    logic        field_bit;
    logic [12:0] raw_frame;
  } out_item_t;

  // Classified edge, passed from front to back through the queue
  typedef struct packed {
    logic       abort;
    logic       rising;
    pulse_cls_t cls;
  } edge_entry_t;

  // Rising-edge table, by last bit and pulse class
  function automatic edge_act_t rise_act(input logic last, input pulse_cls_t cls);
    edge_act_t act;
    act = ACT_BAD;
    case (cls)
      CLS_ONE_T: act = last ? ACT_NONE : ACT_ZERO;
      CLS_TWO_T: act = last ? ACT_ZERO : ACT_BAD;
      default:   act = ACT_BAD;
    endcase
    return act;
  endfunction

  // Falling-edge table, by last bit and pulse class
  function automatic edge_act_t fall_act(input logic last, input pulse_cls_t cls);
    edge_act_t act;
    act = ACT_BAD;
    case (cls)
      CLS_ONE_T: act = last ? ACT_ONE : ACT_NONE;
      CLS_TWO_T: act = last ? ACT_BAD : ACT_ONE;
      default:   act = ACT_BAD;
    endcase
    return act;
  endfunction

endpackage

// File: design/rc5d_front.sv
// Front end: pulse limit registers, input handshake and pulse classification.
// Depends on rc5d_pkg; feeds rc5d_queue.

module rc5d_front import rc5d_pkg::*; #(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output edge_entry_t          q_entry
);

  // Bits of ticks and limits that take part in the compare
  localparam logic [CFG_W-1:0] TICK_MASK = (TICK_WIDTH >= CFG_W) ? {CFG_W{1'b1}} :
      CFG_W'((33'd1 << TICK_WIDTH) - 33'd1);

  logic [CFG_W-1:0] one_t_min_r, one_t_max_r, two_t_min_r, two_t_max_r;
  logic [CFG_W-1:0] ticks, lo1, hi1, lo2, hi2;
  pulse_cls_t       cls;

  // Write limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_t_min_r <= ONE_T_MIN_RST;
      one_t_max_r <= ONE_T_MAX_RST;
      two_t_min_r <= TWO_T_MIN_RST;
      two_t_max_r <= TWO_T_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ONE_T_MIN: one_t_min_r <= cfg_wdata;
        REG_ONE_T_MAX: one_t_max_r <= cfg_wdata;
        REG_TWO_T_MIN: two_t_min_r <= cfg_wdata;
        REG_TWO_T_MAX: two_t_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify pulse; 1T wins where the ranges overlap
  always_comb begin
    ticks = in_data.pulse_ticks & TICK_MASK;
    lo1   = one_t_min_r & TICK_MASK;
    hi1   = one_t_max_r & TICK_MASK;
    lo2   = two_t_min_r & TICK_MASK;
    hi2   = two_t_max_r & TICK_MASK;
    if (ticks > lo1 && ticks < hi1) begin
      cls = CLS_ONE_T;
    end else if (ticks > lo2 && ticks < hi2) begin
      cls = CLS_TWO_T;
    end else begin
      cls = CLS_BAD;
    end
  end

  // Hand the classified edge to the queue
  assign in_ready        = !q_full;
  assign q_push          = in_valid && !q_full;
  assign q_entry.abort   = in_data.req_type;
  assign q_entry.rising  = in_data.edge_rising;
  assign q_entry.cls     = cls;

endmodule

// File: design/rc5d_queue.sv
// Two-entry queue of classified edges between front and back end.
// Depends on rc5d_pkg.

module rc5d_queue import rc5d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  edge_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output edge_entry_t head
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  edge_entry_t       mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries; no reset on payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: design/rc5d_back.sv
// Back end: Manchester state update, frame shift register and result register.
// Depends on rc5d_pkg; drains rc5d_queue.

module rc5d_back import rc5d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  edge_entry_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam logic [LEFT_W-1:0] LEFT_RST = LEFT_W'(FRAME_BITS - 1);

  logic [FRAME_BITS-1:0] frame_r, frame_nxt, frame_or;
  logic [LEFT_W-1:0]     left_r, left_nxt;
  logic                  last_bit_r, last_bit_nxt;
  logic                  await_fall_r, await_fall_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  edge_act_t             act;
  logic                  pkt_reset, emit;

  // Take an edge whenever the result slot is free or being drained
  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  // Pick the table action for the edge at the head
  always_comb begin
    act       = ACT_NONE;
    pkt_reset = 1'b0;
    if (q_head.abort) begin
      pkt_reset = 1'b1;
    end else if (q_head.rising) begin
      if (q_head.cls == CLS_BAD) begin
        pkt_reset = 1'b1;
      end else begin
        act = rise_act(last_bit_r, q_head.cls);
      end
    end else if (!await_fall_r) begin
      if (q_head.cls == CLS_BAD) begin
        pkt_reset = 1'b1;
      end else begin
        act = fall_act(last_bit_r, q_head.cls);
      end
    end
  end

  // Update packet state and build the result
  always_comb begin
    frame_nxt      = frame_r;
    left_nxt       = left_r;
    last_bit_nxt   = last_bit_r;
    await_fall_nxt = await_fall_r;
    emit           = 1'b0;
    frame_or       = frame_r | FRAME_BITS'(act == ACT_ONE);
    out_data_nxt.address    = frame_or[10:6] & ADDR_MASK;
    out_data_nxt.command    = {~frame_or[12], frame_or[5:0] & CMD_LOW_MASK};
    out_data_nxt.toggle_bit = frame_or[11];
    out_data_nxt.field_bit  = frame_or[12];
    out_data_nxt.raw_frame  = frame_or[12:0];
    if (q_pop) begin
      if (!q_head.abort && !q_head.rising && await_fall_r) begin
        await_fall_nxt = 1'b0;
      end
      if (pkt_reset || act == ACT_BAD) begin
        frame_nxt      = '0;
        left_nxt       = LEFT_RST;
        last_bit_nxt   = 1'b1;
        await_fall_nxt = 1'b1;
      end else if (act == ACT_ZERO || act == ACT_ONE) begin
        if (left_r != '0) begin
          frame_nxt    = frame_or << 1;
          left_nxt     = left_r - 1'b1;
          last_bit_nxt = (act == ACT_ONE);
        end else begin
          // Last bit in: emit and start over
          emit           = 1'b1;
          frame_nxt      = '0;
          left_nxt       = LEFT_RST;
          last_bit_nxt   = 1'b1;
          await_fall_nxt = 1'b1;
        end
      end
    end
  end

  // Set, hold or drop the result register
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r      <= '0;
      left_r       <= LEFT_RST;
      last_bit_r   <= 1'b1;
      await_fall_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      frame_r      <= frame_nxt;
      left_r       <= left_nxt;
      last_bit_r   <= last_bit_nxt;
      await_fall_r <= await_fall_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Bit counter never runs above the frame length
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= LEFT_RST)
    else $error("bit counter out of range");

  // An abort leaves a fresh packet behind
  a_abort_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.abort) |=>
      (left_r == LEFT_RST && await_fall_r && last_bit_r && frame_r == '0))
    else $error("abort did not reset packet");

  // A completed frame shows up as a valid result next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("completed frame not presented");

  // Never pop over an undelivered result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !q_pop)
    else $error("edge taken while result stalled");

endmodule

// File: design/rc5_ir_edge_decoder_core.sv
// Top level of the RC5 IR edge decoder: front end, edge queue, back end.
// Depends on rc5d_pkg, rc5d_front, rc5d_queue and rc5d_back.

// The decoder takes one edge or abort item per clock cycle while in_ready is
// high and gives at most one decoded frame per item. An item is classified
// against the four pulse limit registers in the cycle it is accepted, waits in
// a two-entry queue, and is applied to the Manchester state by the back end,
// whose state update sets the rate of one item per cycle while the result
// register is free or being drained. A frame appears on the result port from
// a result register, after the item carrying its last bit has passed through
// the queue; while that result is not taken the back end holds and the queue
// fills, after which in_ready drops. Limit registers may be written only while
// no item is in flight.

module rc5_ir_edge_decoder_core import rc5d_pkg::*; #(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  logic        q_push, q_full, q_pop, q_not_empty;
  edge_entry_t q_entry, q_head;

  rc5d_front #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  rc5d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  rc5d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// File: tb/tb_rc5_ir_edge_decoder_core.sv
// Testbench for rc5_ir_edge_decoder_core: drives IR edge and abort transactions,
// predicts every decoded RC5 frame and checks it field by field on the result port.
// Depends on rc5d_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_rc5_ir_edge_decoder_core;
  import rc5d_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ONE_T_MIN;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;

  // Pending edge transactions and frames still owed by the decoder
  in_item_t  stim_q[$];
  out_item_t frames_due[$];

  // Decoder model: pulse limits and Manchester packet state
  logic [15:0] pulse_limit [4] = '{16'd630, 16'd1170, 16'd1530, 16'd2070};
  logic [12:0] frame_acc;
  logic [3:0]  bits_to_go;
  logic        prev_bit;
  logic        first_fall_pending;

  int  errors = 0;
  int  items_sent = 0;
  int  frames_seen = 0;
  int  settings_used = 1;
  int  cycle_count = 0;
  bit  steady = 1'b0;

  rc5_ir_edge_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  function automatic void clear_packet();
    frame_acc          = '0;
    bits_to_go         = 4'(FRAME_BITS - 1);
    prev_bit           = 1'b1;
    first_fall_pending = 1'b1;
  endfunction

  function automatic pulse_cls_t class_of(logic [15:0] ticks);
    if (ticks > pulse_limit[REG_ONE_T_MIN] && ticks < pulse_limit[REG_ONE_T_MAX])
      return CLS_ONE_T;
    if (ticks > pulse_limit[REG_TWO_T_MIN] && ticks < pulse_limit[REG_TWO_T_MAX])
      return CLS_TWO_T;
    return CLS_BAD;
  endfunction

  // Advance the packet state by one transaction; return 1 when a frame completes
  function automatic bit decode_edge(input in_item_t it, output out_item_t frame);
    pulse_cls_t cls;
    edge_act_t  act;
    frame = '0;
    if (it.req_type) begin
      clear_packet();
      return 1'b0;
    end
    cls = class_of(it.pulse_ticks);
    if (it.edge_rising) begin
      if (cls == CLS_BAD) begin
        clear_packet();
        return 1'b0;
      end
      if (cls == CLS_ONE_T) act = prev_bit ? ACT_NONE : ACT_ZERO;
      else act = prev_bit ? ACT_ZERO : ACT_BAD;
    end else begin
      // first falling edge of a packet only arms the decoder
      if (first_fall_pending) begin
        first_fall_pending = 1'b0;
        return 1'b0;
      end
      if (cls == CLS_BAD) begin
        clear_packet();
        return 1'b0;
      end
      if (cls == CLS_ONE_T) act = prev_bit ? ACT_ONE : ACT_NONE;
      else act = prev_bit ? ACT_BAD : ACT_ONE;
    end
    if (act == ACT_NONE) return 1'b0;
    if (act == ACT_BAD) begin
      clear_packet();
      return 1'b0;
    end
    prev_bit  = (act == ACT_ONE);
    frame_acc = frame_acc | {12'b0, prev_bit};
    if (bits_to_go != 0) begin
      frame_acc  = frame_acc << 1;
      bits_to_go = bits_to_go - 4'd1;
      return 1'b0;
    end
    frame.address    = frame_acc[10:6];
    frame.command    = {~frame_acc[12], frame_acc[5:0]};
    frame.toggle_bit = frame_acc[11];
    frame.field_bit  = frame_acc[12];
    frame.raw_frame  = frame_acc;
    clear_packet();
    return 1'b1;
  endfunction

  function automatic in_item_t edge_item(bit rising, logic [15:0] ticks);
    in_item_t it;
    it.req_type    = 1'b0;
    it.pulse_ticks = ticks;
    it.edge_rising = rising;
    return it;
  endfunction

  // Abort carries random payload, which the decoder must ignore
  function automatic in_item_t abort_item();
    in_item_t it;
    it.req_type    = 1'b1;
    it.pulse_ticks = 16'($urandom);
    it.edge_rising = 1'($urandom);
    return it;
  endfunction

  // Pick a pulse length inside the 1T (run 1) or 2T (run 2) window if it is open
  function automatic logic [15:0] pulse_len(int run);
    int lo;
    int hi;
    lo = (run == 1) ? pulse_limit[REG_ONE_T_MIN] : pulse_limit[REG_TWO_T_MIN];
    hi = (run == 1) ? pulse_limit[REG_ONE_T_MAX] : pulse_limit[REG_TWO_T_MAX];
    if (hi - lo >= 2) return 16'($urandom_range(hi - 1, lo + 1));
    return 16'($urandom);
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.req_type    = ($urandom_range(11) == 0);
    it.edge_rising = 1'($urandom);
    case ($urandom_range(3))
      0: it.pulse_ticks = 16'($urandom);
      1: it.pulse_ticks = pulse_limit[$urandom_range(3)] + 16'($urandom_range(2)) - 16'd1;
      2: it.pulse_ticks = pulse_len(1);
      default: it.pulse_ticks = pulse_len(2);
    endcase
    return it;
  endfunction

  // Manchester-encode one frame after a start bit; a 1 is high then low.
  // Optionally spoil one transaction to break the sequence.
  function automatic void push_frame(logic [12:0] bits, bit spoil);
    in_item_t seq[$];
    bit       level;
    bit       first_half;
    int       run;
    int       pos;
    seq.push_back(abort_item());
    seq.push_back(edge_item(1'b0, 16'($urandom)));
    level = 1'b0;
    run   = 1;
    for (int i = FRAME_BITS - 1; i >= 0; i--) begin
      first_half = bits[i];
      if (first_half != level) begin
        seq.push_back(edge_item(first_half, pulse_len(run)));
        level = first_half;
        run   = 1;
      end else begin
        run++;
      end
      // mid-bit transition carries the bit
      seq.push_back(edge_item(~first_half, pulse_len(run)));
      level = ~first_half;
      run   = 1;
    end
    if (spoil) begin
      pos = $urandom_range(seq.size() - 1, 1);
      case ($urandom_range(3))
        0: seq[pos].pulse_ticks = 16'($urandom);
        1: seq[pos].edge_rising = ~seq[pos].edge_rising;
        2: seq[pos] = abort_item();
        default: seq.delete(pos);
      endcase
    end
    foreach (seq[k]) stim_q.push_back(seq[k]);
  endfunction

  // Mostly well-formed frames with random content, the rest noise
  function automatic void fill_phase(int target);
    logic [12:0] bits;
    while (stim_q.size() < target) begin
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(9))
          0: bits = '1;
          1: bits = '0;
          default: bits = 13'($urandom);
        endcase
        push_frame(bits, $urandom_range(99) < 20);
      end else begin
        repeat ($urandom_range(5, 1)) stim_q.push_back(noise_item());
      end
    end
  endfunction

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    pulse_limit[idx] = val;
  endtask

  task automatic set_limits(logic [15:0] lo1, logic [15:0] hi1,
                            logic [15:0] lo2, logic [15:0] hi2);
    write_limit(REG_ONE_T_MIN, lo1);
    write_limit(REG_ONE_T_MAX, hi1);
    write_limit(REG_TWO_T_MIN, lo2);
    write_limit(REG_TWO_T_MAX, hi2);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Hold until every transaction is taken and every frame has come, then drain
  task automatic wait_idle();
    do @(posedge clk);
    while (stim_q.size() != 0 || in_valid || frames_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: present queued transactions, predict each one as it is accepted
  always @(posedge clk) begin : driver
    out_item_t due;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        items_sent++;
        if (decode_edge(in_data, due)) frames_due.push_back(due);
      end
      if (stim_q.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
        in_valid <= 1'b1;
        in_data  <= stim_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side backpressure
  always @(posedge clk) begin
    out_ready <= rst_n && (steady || $urandom_range(99) >= 31);
  end

  // Monitor: compare each frame transaction with the oldest prediction
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame, raw %h", out_data.raw_frame));
      end else begin
        want = frames_due.pop_front();
        frames_seen++;
        if (out_data.address !== want.address)
          report_mismatch($sformatf("address %h, want %h", out_data.address, want.address));
        if (out_data.command !== want.command)
          report_mismatch($sformatf("command %h, want %h", out_data.command, want.command));
        if (out_data.toggle_bit !== want.toggle_bit)
          report_mismatch($sformatf("toggle_bit %b, want %b",
                                    out_data.toggle_bit, want.toggle_bit));
        if (out_data.field_bit !== want.field_bit)
          report_mismatch($sformatf("field_bit %b, want %b",
                                    out_data.field_bit, want.field_bit));
        if (out_data.raw_frame !== want.raw_frame)
          report_mismatch($sformatf("raw_frame %h, want %h",
                                    out_data.raw_frame, want.raw_frame));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d frames outstanding",
               cycle_count, frames_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : main
    int lo1;
    int hi1;
    int lo2;
    int hi2;
    clear_packet();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: abort, first fall, limit boundaries and every table entry
    stim_q.push_back(abort_item());
    stim_q.push_back(edge_item(1'b1, 16'd1531));   // rising 2T before first fall
    stim_q.push_back(edge_item(1'b0, 16'd0));      // first fall, ignored
    stim_q.push_back(edge_item(1'b0, 16'd1530));   // on 2T lower limit: invalid
    stim_q.push_back(edge_item(1'b0, 16'hFFFF));   // first fall, ignored
    stim_q.push_back(edge_item(1'b1, 16'd631));    // 1T after a one: no bit
    stim_q.push_back(edge_item(1'b0, 16'd1169));   // 1T fall after a one
    stim_q.push_back(edge_item(1'b0, 16'd2069));   // 2T fall after a one: bad
    stim_q.push_back(edge_item(1'b0, 16'd2070));   // first fall, ignored
    stim_q.push_back(edge_item(1'b1, 16'd2069));   // 2T rise after a one
    stim_q.push_back(edge_item(1'b1, 16'd1169));   // 1T rise after a zero
    stim_q.push_back(edge_item(1'b0, 16'd631));    // 1T fall after a zero: no bit
    stim_q.push_back(edge_item(1'b0, 16'd1531));   // 2T fall after a zero
    stim_q.push_back(edge_item(1'b1, 16'd1600));   // 2T rise after a one
    stim_q.push_back(edge_item(1'b1, 16'd1600));   // 2T rise after a zero: bad
    stim_q.push_back(edge_item(1'b0, 16'd5));      // first fall, ignored
    stim_q.push_back(edge_item(1'b1, 16'd1170));   // on 1T upper limit: invalid
    stim_q.push_back(edge_item(1'b1, 16'd630));    // on 1T lower limit: invalid
    stim_q.push_back(edge_item(1'b1, 16'hFFFF));
    stim_q.push_back(abort_item());
    fill_phase(370);
    wait_idle();

    // Tightest windows at the bottom of the range, no idling on either side
    steady = 1'b1;
    set_limits(16'd0, 16'd2, 16'd1, 16'd3);
    fill_phase(250);
    wait_idle();
    steady = 1'b0;

    // 1T window at the top of the range, 2T window below it
    set_limits(16'd65532, 16'hFFFF, 16'd0, 16'd65532);
    fill_phase(250);
    wait_idle();

    // Overlapping windows: overlap counts as 1T
    set_limits(16'd100, 16'd400, 16'd300, 16'd700);
    fill_phase(250);
    wait_idle();

    // Closed windows: every edge is invalid
    set_limits(16'd500, 16'd500, 16'hFFFF, 16'd0);
    fill_phase(60);
    wait_idle();

    // Random disjoint windows
    repeat (2) begin
      lo1 = $urandom_range(1500);
      hi1 = lo1 + $urandom_range(800, 2);
      lo2 = hi1 + $urandom_range(400);
      hi2 = lo2 + $urandom_range(1500, 2);
      set_limits(16'(lo1), 16'(hi1), 16'(lo2), 16'(hi2));
      fill_phase(200);
      wait_idle();
    end

    $display("Run covered %0d edge and abort transactions and %0d decoded frames",
             items_sent, frames_seen);
    $display("across %0d pulse limit settings, with %0d mismatches",
             settings_used, errors);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
